@@ rtl/adw_pkg.sv @@
// Shared types and constants for the Adam weight-update pipeline.
// Used by adam_weight_update and adw_divider; depends on nothing else.
`timescale 1ns / 1ps

package adw_pkg;

    // vector storage
    localparam int VECTOR_DEPTH = 1024;
    localparam int ADDR_W       = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int IDX_W        = 10;

    // configuration port
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DECAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_DECAY = 2'd2;
    localparam logic [CFG_W-1:0] STEP_RATE_RST    = 24'd16777;
    localparam logic [CFG_W-1:0] FIRST_DECAY_RST  = 24'd15099494;
    localparam logic [CFG_W-1:0] SECOND_DECAY_RST = 24'd16760438;

    // commands
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // fixed point
    localparam int C_W = 25;
    localparam logic [C_W-1:0] ONE_Q24 = 25'h1000000;
    localparam logic [71:0] STEP_MAX = 72'h2_0000_0000;

    // pipelined restoring divider
    localparam int DIV_N_W    = 72;
    localparam int DIV_D_W    = 33;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = DIV_N_W / DIV_BITS;

    // pipelined square root, 64-bit radicand
    localparam int SQ_PER_STAGE = 4;
    localparam int SQ_STAGES    = 32 / SQ_PER_STAGE;

    // sideband line from the moment write stage to the weight stage
    localparam int SB_LEN = 1 + DIV_STAGES + 1 + SQ_STAGES + DIV_STAGES;

    typedef struct packed {
        logic [DIV_D_W:0]   rem;
        logic [DIV_N_W-1:0] nq;
        logic [DIV_D_W-1:0] den;
    } t_div;

    typedef struct packed {
        logic [35:0] rem;
        logic [31:0] res;
        logic [63:0] x;
    } t_sq;

    typedef struct packed {
        logic                valid;
        logic                cmd;
        logic                ok;
        logic [IDX_W-1:0]    idx;
        logic signed [31:0]  value;
        logic                last;
        logic [C_W-1:0]      c1;
        logic [C_W-1:0]      c2;
    } t_front;

    typedef struct packed {
        logic                wr;
        logic [IDX_W-1:0]    idx;
        logic signed [47:0]  m;
        logic [47:0]         v;
    } t_moment;

    typedef struct packed {
        logic                valid;
        logic                cmd;
        logic                ok;
        logic [IDX_W-1:0]    idx;
        logic signed [31:0]  value;
        logic                last;
        logic                neg;
    } t_side;

    typedef struct packed {
        logic                valid;
        logic                wr;
        logic [IDX_W-1:0]    idx;
        logic                last;
        logic signed [31:0]  w;
    } t_fin;

    typedef struct packed {
        logic [IDX_W-1:0]    idx;
        logic signed [31:0]  w;
        logic                last;
    } t_res;

endpackage

@@ rtl/adw_divider.sv @@
// Pipelined restoring divider, DIV_BITS quotient bits per stage.
// Depends on adw_pkg for widths and the stage record type.
`timescale 1ns / 1ps

module adw_divider
    import adw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_adv,
    input  logic [DIV_N_W-1:0] i_num,
    input  logic [DIV_D_W-1:0] i_den,
    output logic [DIV_N_W-1:0] o_quo
);

    t_div r_st [DIV_STAGES];
    t_div n_st [DIV_STAGES];

    // one shift-compare-subtract step
    function automatic t_div f_step(input t_div s);
        t_div o;
        logic [DIV_D_W:0] remx;
        remx = {s.rem[DIV_D_W-1:0], s.nq[DIV_N_W-1]};
        o = s;
        o.nq = {s.nq[DIV_N_W-2:0], 1'b0};
        if (remx >= {1'b0, s.den}) begin
            o.rem   = remx - {1'b0, s.den};
            o.nq[0] = 1'b1;
        end else begin
            o.rem = remx;
        end
        return o;
    endfunction

    // work each stage on its predecessor
    always_comb begin
        t_div s;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                s.rem = '0;
                s.nq  = i_num;
                s.den = i_den;
            end else begin
                s = r_st[k-1];
            end
            for (int b = 0; b < DIV_BITS; b++) begin
                s = f_step(s);
            end
            n_st[k] = s;
        end
    end

    // advance with the pipeline, hold on stall
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_st <= n_st;
        end
    end

    assign o_quo = r_st[DIV_STAGES-1].nq;

endmodule

@@ rtl/adam_weight_update.sv @@
// Adam optimizer step over a stored vector of VECTOR_DEPTH weights, one element per
// transaction. A load writes a weight and clears its moments; an update applies one
// gradient element and returns the new weight. The pipeline takes one transaction every
// cycle while o_stall is low, including repeated hits on the same element; each result
// passes through two 18-stage dividers and an 8-stage square root in series.
// Moments and weights live in single-port-write memories with forwarding around
// their read-modify-write stages. A two-entry output register (output plus skid) lets
// the input keep taking transactions while a result waits.
// The stores are undefined until each element is loaded, so there is no clearing pass.
// Depends on adw_pkg and adw_divider.
`timescale 1ns / 1ps

module adam_weight_update
    import adw_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_cmd,
    input  logic [IDX_W-1:0]        i_elem_index,
    input  logic signed [31:0]      i_value,
    input  logic                    i_end_of_pass,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [IDX_W-1:0]        o_out_index,
    output logic signed [31:0]      o_new_weight,
    output logic                    o_out_last,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    // configuration and step powers
    logic [CFG_W-1:0] r_alpha, r_beta1, r_beta2;
    logic [C_W-1:0]   r_pow1, r_pow2;

    // pipeline
    logic    adv, w_in_acc, w_ok;
    logic [48:0] w_p1_prod, w_p2_prod;
    logic [C_W-1:0] w_p1, w_p2;
    t_front  r_s1, r_s2;
    logic [47:0] r_s2_gsq;
    logic [31:0] w_gmag;
    logic [63:0] w_gsq;
    t_moment r_m3, r_m4;
    logic [C_W-1:0] r_s3_c1, r_s3_c2;
    logic signed [47:0] r_mean_rd, w_m_old, w_m_new;
    logic [47:0] r_sq_rd, w_v_old, w_v_new;
    logic signed [47:0] r_mean_mem [VECTOR_DEPTH];
    logic [47:0] r_sq_mem [VECTOR_DEPTH];
    logic signed [31:0] r_w_mem [VECTOR_DEPTH];
    t_side   r_sb [SB_LEN];
    logic [47:0] w_mmag;
    logic [DIV_N_W-1:0] w_qa, w_qb, w_qc;
    logic [63:0] r_mhat, r_vhat;
    t_sq     r_sq [SQ_STAGES];
    t_sq     n_sq [SQ_STAGES];
    logic [63:0] r_prod_hi;
    logic [23:0] r_prod_lo;
    logic [47:0] w_lo_full;
    logic [64:0] w_num_sum;
    logic [63:0] r_num_dl [SQ_STAGES-1];
    logic [DIV_D_W-1:0] w_den;
    logic [33:0] w_step;
    logic signed [31:0] r_w_rd, w_w_old, w_w_new;
    logic signed [35:0] w_w_sum;
    t_fin    r_fin, r_fin2;
    t_res    r_o, r_skid, w_fin_res;
    logic    r_o_valid, r_skid_valid, w_take, w_deliver;

    function automatic logic [ADDR_W-1:0] f_addr(input logic [IDX_W-1:0] idx);
        return ADDR_W'(idx);
    endfunction

    // floor(mag * b / 2^24) as two partial products
    function automatic logic [48:0] f_mul_q24(input logic [48:0] mag, input logic [24:0] b);
        logic [49:0] hi;
        logic [48:0] lo;
        hi = 50'(mag[48:24]) * 50'(b);
        lo = 49'(mag[23:0]) * 49'(b);
        return 49'(hi + 50'(lo[48:24]));
    endfunction

    // move a toward target by b/2^24 of the gap, truncated toward zero
    function automatic logic [47:0] f_blend(input logic signed [48:0] a,
                                            input logic signed [48:0] target,
                                            input logic [24:0] b);
        logic signed [49:0] d;
        logic [48:0] mv;
        logic signed [49:0] r;
        d  = 50'(target) - 50'(a);
        mv = f_mul_q24(49'(d < 0 ? -d : d), b);
        r  = (d < 0) ? 50'(a) - $signed({1'b0, mv}) : 50'(a) + $signed({1'b0, mv});
        return 48'(r);
    endfunction

    // one digit of the integer square root
    function automatic t_sq f_sq_step(input t_sq s);
        t_sq o;
        logic [35:0] remx, trial;
        remx  = {s.rem[33:0], s.x[63:62]};
        trial = {2'b00, s.res, 2'b01};
        o.x   = {s.x[61:0], 2'b00};
        if (remx >= trial) begin
            o.rem = remx - trial;
            o.res = {s.res[30:0], 1'b1};
        end else begin
            o.rem = remx;
            o.res = {s.res[30:0], 1'b0};
        end
        return o;
    endfunction

    // the pipeline moves unless the skid register is occupied
    assign adv      = !r_skid_valid;
    assign o_stall  = r_skid_valid;
    assign w_in_acc = i_valid && adv;
    assign w_ok     = (32'(i_elem_index) < 32'(VECTOR_DEPTH));

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= STEP_RATE_RST;
            r_beta1 <= FIRST_DECAY_RST;
            r_beta2 <= SECOND_DECAY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STEP_RATE:    r_alpha <= i_cfg_data;
                CFG_FIRST_DECAY:  r_beta1 <= i_cfg_data;
                CFG_SECOND_DECAY: r_beta2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // powers for this transaction; advance them on an accepted end-of-pass update
    assign w_p1_prod = 49'(r_pow1) * 49'(r_beta1);
    assign w_p2_prod = 49'(r_pow2) * 49'(r_beta2);
    assign w_p1      = w_p1_prod[48:24];
    assign w_p2      = w_p2_prod[48:24];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pow1 <= ONE_Q24;
            r_pow2 <= ONE_Q24;
        end else if (w_in_acc && i_cmd == CMD_UPDATE && i_end_of_pass) begin
            r_pow1 <= w_p1;
            r_pow2 <= w_p2;
        end
    end

    // stage 1: capture; stage 2: gradient square
    assign w_gmag = r_s1.value[31] ? 32'(-r_s1.value) : 32'(r_s1.value);
    assign w_gsq  = 64'(w_gmag) * 64'(w_gmag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
        end else if (adv) begin
            r_s1.valid <= w_in_acc;
            r_s1.cmd   <= i_cmd;
            r_s1.ok    <= w_ok;
            r_s1.idx   <= i_elem_index;
            r_s1.value <= i_value;
            r_s1.last  <= i_end_of_pass;
            r_s1.c1    <= ONE_Q24 - w_p1;
            r_s1.c2    <= ONE_Q24 - w_p2;
            r_s2       <= r_s1;
            r_s2_gsq   <= (|w_gsq[63:48]) ? '1 : w_gsq[47:0];
        end
    end

    // moment memories: read for stage 2, write back from stage 3
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mean_rd <= r_mean_mem[f_addr(r_s1.idx)];
            r_sq_rd   <= r_sq_mem[f_addr(r_s1.idx)];
            if (r_m3.wr) begin
                r_mean_mem[f_addr(r_m3.idx)] <= r_m3.m;
                r_sq_mem[f_addr(r_m3.idx)]   <= r_m3.v;
            end
        end
    end

    // forward moments not yet in memory, newest first
    always_comb begin
        if (r_m3.wr && r_m3.idx == r_s2.idx) begin
            w_m_old = r_m3.m;
            w_v_old = r_m3.v;
        end else if (r_m4.wr && r_m4.idx == r_s2.idx) begin
            w_m_old = r_m4.m;
            w_v_old = r_m4.v;
        end else begin
            w_m_old = r_mean_rd;
            w_v_old = r_sq_rd;
        end
    end

    assign w_m_new = $signed(f_blend(49'(w_m_old), 49'($signed({r_s2.value, 16'h0000})),
                                     ONE_Q24 - {1'b0, r_beta1}));
    assign w_v_new = f_blend($signed({1'b0, w_v_old}), $signed({1'b0, r_s2_gsq}),
                             ONE_Q24 - {1'b0, r_beta2});

    // stage 3: new moments, written on the next advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3.wr <= 1'b0;
            r_m4.wr <= 1'b0;
        end else if (adv) begin
            r_m3.wr  <= r_s2.valid && r_s2.ok;
            r_m3.idx <= r_s2.idx;
            r_m3.m   <= (r_s2.cmd == CMD_LOAD) ? '0 : w_m_new;
            r_m3.v   <= (r_s2.cmd == CMD_LOAD) ? '0 : w_v_new;
            r_s3_c1  <= r_s2.c1;
            r_s3_c2  <= r_s2.c2;
            r_m4     <= r_m3;
        end
    end

    // sideband line alongside the arithmetic
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SB_LEN; k++) begin
                r_sb[k].valid <= 1'b0;
            end
        end else if (adv) begin
            r_sb[0].valid <= r_s2.valid;
            r_sb[0].cmd   <= r_s2.cmd;
            r_sb[0].ok    <= r_s2.ok;
            r_sb[0].idx   <= r_s2.idx;
            r_sb[0].value <= r_s2.value;
            r_sb[0].last  <= r_s2.last;
            r_sb[0].neg   <= (r_s2.cmd == CMD_UPDATE) && w_m_new[47];
            for (int k = 1; k < SB_LEN; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // bias corrections: |m| * 2^24 / c1 and v * 2^24 / c2
    assign w_mmag = r_m3.m[47] ? 48'(-r_m3.m) : 48'(r_m3.m);

    adw_divider u_div_mean (
        .i_clk (i_clk),
        .i_adv (adv),
        .i_num ({w_mmag, 24'h000000}),
        .i_den (DIV_D_W'(r_s3_c1)),
        .o_quo (w_qa)
    );

    adw_divider u_div_square (
        .i_clk (i_clk),
        .i_adv (adv),
        .i_num ({r_m3.v, 24'h000000}),
        .i_den (DIV_D_W'(r_s3_c2)),
        .o_quo (w_qb)
    );

    // saturate corrected moments to 64 bits
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mhat <= (|w_qa[71:64]) ? '1 : w_qa[63:0];
            r_vhat <= (|w_qb[71:64]) ? '1 : w_qb[63:0];
        end
    end

    // square root of corrected v, SQ_PER_STAGE digits per stage
    always_comb begin
        t_sq s;
        for (int k = 0; k < SQ_STAGES; k++) begin
            if (k == 0) begin
                s.rem = '0;
                s.res = '0;
                s.x   = r_vhat;
            end else begin
                s = r_sq[k-1];
            end
            for (int j = 0; j < SQ_PER_STAGE; j++) begin
                s = f_sq_step(s);
            end
            n_sq[k] = s;
        end
    end

    // numerator: corrected |m| times alpha, saturated
    assign w_lo_full = 48'(r_mhat[23:0]) * 48'(r_alpha);
    assign w_num_sum = 65'(r_prod_hi) + 65'(r_prod_lo);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq        <= n_sq;
            r_prod_hi   <= 64'(r_mhat[63:24]) * 64'(r_alpha);
            r_prod_lo   <= w_lo_full[47:24];
            r_num_dl[0] <= w_num_sum[64] ? '1 : w_num_sum[63:0];
            for (int k = 1; k < SQ_STAGES - 1; k++) begin
                r_num_dl[k] <= r_num_dl[k-1];
            end
        end
    end

    // step = numerator / (sqrt + eps)
    assign w_den = DIV_D_W'(r_sq[SQ_STAGES-1].res) + DIV_D_W'(1);

    adw_divider u_div_step (
        .i_clk (i_clk),
        .i_adv (adv),
        .i_num (DIV_N_W'(r_num_dl[SQ_STAGES-2])),
        .i_den (w_den),
        .o_quo (w_qc)
    );

    assign w_step = (w_qc > STEP_MAX) ? STEP_MAX[33:0] : w_qc[33:0];

    // weight memory: read for the last arithmetic stage, write back from the final stage
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_w_rd <= r_w_mem[f_addr(r_sb[SB_LEN-2].idx)];
            if (r_fin.wr) begin
                r_w_mem[f_addr(r_fin.idx)] <= r_fin.w;
            end
        end
    end

    // forward weights not yet in memory, then apply the step or load the value
    always_comb begin
        if (r_fin.wr && r_fin.idx == r_sb[SB_LEN-1].idx) begin
            w_w_old = r_fin.w;
        end else if (r_fin2.wr && r_fin2.idx == r_sb[SB_LEN-1].idx) begin
            w_w_old = r_fin2.w;
        end else begin
            w_w_old = r_w_rd;
        end
        w_w_sum = r_sb[SB_LEN-1].neg ? 36'(w_w_old) + $signed({2'b00, w_step})
                                     : 36'(w_w_old) - $signed({2'b00, w_step});
        if (!r_sb[SB_LEN-1].ok) begin
            w_w_new = '0;
        end else if (r_sb[SB_LEN-1].cmd == CMD_LOAD) begin
            w_w_new = r_sb[SB_LEN-1].value;
        end else if (w_w_sum > 36'sd2147483647) begin
            w_w_new = 32'sh7FFFFFFF;
        end else if (w_w_sum < -36'sd2147483648) begin
            w_w_new = 32'sh80000000;
        end else begin
            w_w_new = 32'(w_w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin.valid  <= 1'b0;
            r_fin.wr     <= 1'b0;
            r_fin2.valid <= 1'b0;
            r_fin2.wr    <= 1'b0;
        end else if (adv) begin
            r_fin.valid <= r_sb[SB_LEN-1].valid;
            r_fin.wr    <= r_sb[SB_LEN-1].valid && r_sb[SB_LEN-1].ok;
            r_fin.idx   <= r_sb[SB_LEN-1].idx;
            r_fin.last  <= r_sb[SB_LEN-1].last;
            r_fin.w     <= w_w_new;
            r_fin2      <= r_fin;
        end
    end

    // output register with skid entry
    assign w_take    = r_o_valid && !i_stall;
    assign w_deliver = adv && r_fin.valid;
    assign w_fin_res = '{idx: r_fin.idx, w: r_fin.w, last: r_fin.last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid    <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_o          <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (w_deliver) begin
            if (!r_o_valid || w_take) begin
                r_o       <= w_fin_res;
                r_o_valid <= 1'b1;
            end else begin
                r_skid       <= w_fin_res;
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_out_index  = r_o.idx;
    assign o_new_weight = r_o.w;
    assign o_out_last   = r_o.last;

`ifndef ASSERT_OFF
    // skid entry only fills behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_o_valid)
        else $error("skid entry valid without output valid");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_o_valid && i_stall))
        else $error("skid entry filled while output was free");

    // every delivered result is presented
    a_deliver_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_fin.valid) |=> r_o_valid)
        else $error("delivered result dropped");

    // powers move only on an accepted end-of-pass update
    a_power_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_in_acc && i_cmd == CMD_UPDATE && i_end_of_pass) |=>
        ($stable(r_pow1) && $stable(r_pow2)))
        else $error("step powers changed without end of pass");
`endif

endmodule
